// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define GCC_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("connectivity check: same-cycle assertion failed");
`define GCC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("connectivity check: next-cycle assertion failed");
`else
`define GCC_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define GCC_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== design/gcc_pkg.sv =====
// Types and constants of the graph connectivity checker.
package gcc_pkg;

   localparam int VERTEX_INDEX_WIDTH = 5;
   localparam int EDGE_INDEX_WIDTH   = 6;
   localparam int VERTEX_COUNT_WIDTH = 6;
   localparam int EDGE_COUNT_WIDTH   = 7;
   localparam int CSR_INDEX_WIDTH    = 1;
   localparam int CSR_DATA_WIDTH     = 7;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VERTEX_COUNT = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EDGE_COUNT   = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LINK_RD,
      ST_LINK_EVAL,
      ST_LINK_FWD,
      ST_LINK_REV,
      ST_WALK_INIT,
      ST_WALK_POP,
      ST_WALK_LOAD,
      ST_WALK_RD,
      ST_WALK_EVAL,
      ST_ANSWER
   } gcc_state_type;

   typedef struct packed {
      logic idle;
      logic done;
      logic connected;
   } gcc_status_type;

endpackage

// ===== design/gcc_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
module gcc_ram #(
   parameter int ADDR_WIDTH = 5,
   parameter int DATA_WIDTH = 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem [(1 << ADDR_WIDTH)];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/gcc_walk_seq.sv =====
// Sequencer: incidence store, link build, depth-first walk and clearing pass.
module gcc_walk_seq #(
   parameter int MAX_VERTICES = 32,
   parameter int MAX_EDGES    = 64,
   localparam int VW  = $clog2(MAX_VERTICES),
   localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
   localparam int VCW = $clog2(MAX_VERTICES + 1),
   localparam int ECW = $clog2(MAX_EDGES + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cell_we,
   input  logic [VW-1:0]           cell_vertex,
   input  logic [EW-1:0]           cell_edge,
   input  logic                    cell_bit,
   input  logic                    start,
   input  logic [VCW-1:0]          nv,
   input  logic [ECW-1:0]          ne,
   input  logic                    rsp_free,
   output gcc_pkg::gcc_status_type status
);
   import gcc_pkg::*;

   localparam int IAW = EW + VW;
   localparam int AAW = 2 * VW;
   localparam int CW  = (IAW > AAW) ? IAW : AAW;

   gcc_state_type state_ff, state_in;

   logic [CW-1:0]           ptr_ff;
   logic [EW-1:0]           be_ff;
   logic [VW-1:0]           bv_ff;
   logic [VW-1:0]           first_ff, last_ff;
   logic                    seen_ff, second_ff;
   logic [VW-1:0]           v_ff, u_ff;
   logic [VCW-1:0]          sp_ff, vcnt_ff;
   logic [MAX_VERTICES-1:0] visited_ff;

   logic           inc_we, inc_wdata, inc_re, inc_rdata;
   logic [IAW-1:0] inc_waddr, inc_raddr;
   logic           adj_we, adj_wdata, adj_re, adj_rdata;
   logic [AAW-1:0] adj_waddr, adj_raddr;
   logic           stk_we, stk_re;
   logic [VW-1:0]  stk_waddr, stk_wdata, stk_raddr, stk_rdata;

   logic hit, col_end, last_col, second_in, push, u_zero, sp_zero, nv_zero, ptr_end;

   gcc_ram #(.ADDR_WIDTH(IAW), .DATA_WIDTH(1)) u_inc_ram (
      .clock   (clock),
      .wr_en   (inc_we),
      .wr_addr (inc_waddr),
      .wr_data (inc_wdata),
      .rd_en   (inc_re),
      .rd_addr (inc_raddr),
      .rd_data (inc_rdata)
   );

   gcc_ram #(.ADDR_WIDTH(AAW), .DATA_WIDTH(1)) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_we),
      .wr_addr (adj_waddr),
      .wr_data (adj_wdata),
      .rd_en   (adj_re),
      .rd_addr (adj_raddr),
      .rd_data (adj_rdata)
   );

   gcc_ram #(.ADDR_WIDTH(VW), .DATA_WIDTH(VW)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_en   (stk_re),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   assign hit       = inc_rdata;
   assign col_end   = (VCW'(bv_ff) == nv - VCW'(1));
   assign last_col  = (ECW'(be_ff) == ne - ECW'(1));
   assign second_in = second_ff | (hit & seen_ff);
   assign push      = adj_rdata & ~visited_ff[u_ff];
   assign u_zero    = (u_ff == '0);
   assign sp_zero   = (sp_ff == '0);
   assign nv_zero   = (nv == '0);
   assign ptr_end   = (ptr_ff == '1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (ptr_end) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               if (nv_zero || ne == '0) state_in = ST_WALK_INIT;
               else                     state_in = ST_LINK_RD;
            end
         end
         ST_LINK_RD: begin
            state_in = ST_LINK_EVAL;
         end
         ST_LINK_EVAL: begin
            if (!col_end)      state_in = ST_LINK_RD;
            else if (second_in) state_in = ST_LINK_FWD;
            else if (last_col) state_in = ST_WALK_INIT;
            else               state_in = ST_LINK_RD;
         end
         ST_LINK_FWD: begin
            state_in = ST_LINK_REV;
         end
         ST_LINK_REV: begin
            state_in = last_col ? ST_WALK_INIT : ST_LINK_RD;
         end
         ST_WALK_INIT: begin
            state_in = nv_zero ? ST_ANSWER : ST_WALK_POP;
         end
         ST_WALK_POP: begin
            state_in = sp_zero ? ST_ANSWER : ST_WALK_LOAD;
         end
         ST_WALK_LOAD: begin
            state_in = ST_WALK_RD;
         end
         ST_WALK_RD: begin
            state_in = ST_WALK_EVAL;
         end
         ST_WALK_EVAL: begin
            state_in = u_zero ? ST_WALK_POP : ST_WALK_RD;
         end
         ST_ANSWER: begin
            if (rsp_free) state_in = ST_CLEAR;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // memory ports and status
   always_comb begin
      inc_we    = 1'b0;
      inc_waddr = '0;
      inc_wdata = 1'b0;
      inc_re    = 1'b0;
      inc_raddr = {be_ff, bv_ff};
      adj_we    = 1'b0;
      adj_waddr = '0;
      adj_wdata = 1'b0;
      adj_re    = 1'b0;
      adj_raddr = {v_ff, u_ff};
      stk_we    = 1'b0;
      stk_waddr = '0;
      stk_wdata = '0;
      stk_re    = 1'b0;
      stk_raddr = VW'(sp_ff - VCW'(1));
      status.idle      = 1'b0;
      status.done      = 1'b0;
      status.connected = (vcnt_ff == nv);
      case (state_ff)
         ST_CLEAR: begin
            inc_we    = 1'b1;
            inc_waddr = ptr_ff[IAW-1:0];
            adj_we    = 1'b1;
            adj_waddr = ptr_ff[AAW-1:0];
         end
         ST_IDLE: begin
            status.idle = 1'b1;
            inc_we      = cell_we;
            inc_waddr   = {cell_edge, cell_vertex};
            inc_wdata   = cell_bit;
         end
         ST_LINK_RD: begin
            inc_re = 1'b1;
         end
         ST_LINK_FWD: begin
            adj_we    = 1'b1;
            adj_waddr = {first_ff, last_ff};
            adj_wdata = 1'b1;
         end
         ST_LINK_REV: begin
            adj_we    = 1'b1;
            adj_waddr = {last_ff, first_ff};
            adj_wdata = 1'b1;
         end
         ST_WALK_INIT: begin
            stk_we = ~nv_zero;
         end
         ST_WALK_POP: begin
            stk_re = ~sp_zero;
         end
         ST_WALK_RD: begin
            adj_re = 1'b1;
         end
         ST_WALK_EVAL: begin
            stk_we    = push;
            stk_waddr = VW'(sp_ff);
            stk_wdata = u_ff;
         end
         ST_ANSWER: begin
            status.done = rsp_free;
         end
         default: ;
      endcase
   end

   // control counters and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         ptr_ff     <= '0;
         be_ff      <= '0;
         bv_ff      <= '0;
         seen_ff    <= 1'b0;
         second_ff  <= 1'b0;
         sp_ff      <= '0;
         vcnt_ff    <= '0;
         visited_ff <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_CLEAR: begin
               ptr_ff <= ptr_ff + CW'(1);
            end
            ST_IDLE: begin
               be_ff     <= '0;
               bv_ff     <= '0;
               seen_ff   <= 1'b0;
               second_ff <= 1'b0;
            end
            ST_LINK_EVAL: begin
               if (!col_end) begin
                  bv_ff     <= bv_ff + VW'(1);
                  seen_ff   <= seen_ff | hit;
                  second_ff <= second_in;
               end else if (!second_in) begin
                  bv_ff     <= '0;
                  be_ff     <= be_ff + EW'(1);
                  seen_ff   <= 1'b0;
                  second_ff <= 1'b0;
               end else begin
                  seen_ff   <= seen_ff | hit;
                  second_ff <= second_in;
               end
            end
            ST_LINK_REV: begin
               bv_ff     <= '0;
               be_ff     <= be_ff + EW'(1);
               seen_ff   <= 1'b0;
               second_ff <= 1'b0;
            end
            ST_WALK_INIT: begin
               if (!nv_zero) begin
                  visited_ff[0] <= 1'b1;
                  sp_ff         <= VCW'(1);
                  vcnt_ff       <= VCW'(1);
               end
            end
            ST_WALK_POP: begin
               if (!sp_zero) sp_ff <= sp_ff - VCW'(1);
            end
            ST_WALK_EVAL: begin
               if (push) begin
                  visited_ff[u_ff] <= 1'b1;
                  sp_ff            <= sp_ff + VCW'(1);
                  vcnt_ff          <= vcnt_ff + VCW'(1);
               end
            end
            ST_ANSWER: begin
               if (rsp_free) begin
                  visited_ff <= '0;
                  sp_ff      <= '0;
                  vcnt_ff    <= '0;
                  ptr_ff     <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   // vertex registers of the build and the walk
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_LINK_EVAL: begin
            if (hit) begin
               if (seen_ff) last_ff  <= bv_ff;
               else         first_ff <= bv_ff;
            end
         end
         ST_WALK_LOAD: begin
            v_ff <= stk_rdata;
            u_ff <= VW'(nv - VCW'(1));
         end
         ST_WALK_EVAL: begin
            if (!u_zero) u_ff <= u_ff - VW'(1);
         end
         default: ;
      endcase
   end

endmodule

// ===== design/graph_connectivity_check.sv =====
// Top level of the graph connectivity checker.
// Incidence cells are taken one beat per cycle while req_stall is low. The beat
// marked last starts the check: a link build reads the cell store one bit at a
// time over vertex_count x edge_count cells and links each column's first and
// last incident vertex, then a depth-first walk from vertex 0 reads
// vertex_count adjacency bits for each reached vertex; the cell and adjacency
// RAMs both have single-bit read ports. Once the result slot is free the result
// beat is offered and a clearing pass over 2^max(log2(MAX_EDGES) +
// log2(MAX_VERTICES), 2*log2(MAX_VERTICES)) addresses (2048 at the defaults)
// wipes both stores; the same pass runs after reset. req_stall is high from the
// last cell until that pass ends.
// Configuration is taken at any time.
`include "assert_macros.svh"

module graph_connectivity_check #(
   parameter int MAX_VERTICES = 32,
   parameter int MAX_EDGES    = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [gcc_pkg::VERTEX_INDEX_WIDTH-1:0] req_vertex_index,
   input  logic [gcc_pkg::EDGE_INDEX_WIDTH-1:0]   req_edge_index,
   input  logic                                   req_incident,
   input  logic                                   req_last_cell,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_connected,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [gcc_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [gcc_pkg::CSR_DATA_WIDTH-1:0]     csr_data
);
   import gcc_pkg::*;

   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int VCW = $clog2(MAX_VERTICES + 1);
   localparam int ECW = $clog2(MAX_EDGES + 1);

   logic [VERTEX_COUNT_WIDTH-1:0] vertex_count_ff;
   logic [EDGE_COUNT_WIDTH-1:0]   edge_count_ff;
   logic                          rsp_valid_ff, rsp_connected_ff;

   logic           req_accept, start, cell_we, rsp_free;
   logic [VCW-1:0] nv;
   logic [ECW-1:0] ne;
   gcc_status_type status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VERTEX_COUNT_WIDTH'(1);
         edge_count_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_VERTEX_COUNT: vertex_count_ff <= csr_data[VERTEX_COUNT_WIDTH-1:0];
            CSR_EDGE_COUNT:   edge_count_ff   <= csr_data[EDGE_COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // counts saturate at the store size
   assign nv = (32'(vertex_count_ff) > MAX_VERTICES) ? VCW'(MAX_VERTICES)
                                                      : VCW'(vertex_count_ff);
   assign ne = (32'(edge_count_ff) > MAX_EDGES) ? ECW'(MAX_EDGES)
                                                 : ECW'(edge_count_ff);

   assign req_stall  = ~status.idle;
   assign req_accept = req_valid & ~req_stall;
   assign start      = req_accept & req_last_cell;
   // cells outside the store are dropped
   assign cell_we    = req_accept && (32'(req_vertex_index) < MAX_VERTICES)
                                  && (32'(req_edge_index) < MAX_EDGES);
   assign rsp_free   = ~rsp_valid_ff | ~rsp_stall;

   gcc_walk_seq #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES)
   ) u_walk_seq (
      .clock       (clock),
      .reset       (reset),
      .cell_we     (cell_we),
      .cell_vertex (VW'(req_vertex_index)),
      .cell_edge   (EW'(req_edge_index)),
      .cell_bit    (req_incident),
      .start       (start),
      .nv          (nv),
      .ne          (ne),
      .rsp_free    (rsp_free),
      .status      (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (status.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (status.done) rsp_connected_ff <= status.connected;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_connected = rsp_connected_ff;

   `GCC_ASSERT_IMPLY(a_result_slot_free, clock, reset, status.done, !rsp_valid_ff || !rsp_stall)
   `GCC_ASSERT_NEXT(a_busy_after_last, clock, reset, start, req_stall)
   `GCC_ASSERT_NEXT(a_clear_after_answer, clock, reset, status.done, req_stall && rsp_valid)

endmodule

// ===== tb/connectivity_monitor.sv =====
`timescale 1ns / 1ps
// Monitor that rebuilds each graph from the cell beats and checks every connectivity answer.
module connectivity_monitor (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic [gcc_pkg::VERTEX_INDEX_WIDTH-1:0] req_vertex_index,
   input  logic [gcc_pkg::EDGE_INDEX_WIDTH-1:0]   req_edge_index,
   input  logic                                   req_incident,
   input  logic                                   req_last_cell,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic                                   rsp_connected,
   input  logic                                   csr_valid,
   input  logic                                   csr_ready,
   input  logic [gcc_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [gcc_pkg::CSR_DATA_WIDTH-1:0]     csr_data,
   output int                                     mismatch_count,
   output int                                     answers_due
);

   localparam int NUM_VERTICES = 32;
   localparam int NUM_EDGES    = 64;

   logic [NUM_EDGES-1:0]                   incidence [NUM_VERTICES];
   logic [gcc_pkg::VERTEX_COUNT_WIDTH-1:0] vertex_count;
   logic [gcc_pkg::EDGE_COUNT_WIDTH-1:0]   edge_count;
   logic                                   connected_due [$];
   logic                                   wanted;

   function automatic void clear_incidence();
      for (int v = 0; v < NUM_VERTICES; v++) incidence[v] = '0;
   endfunction

   // Links each used column's first and last incident row, then floods from vertex 0.
   function automatic logic reach_all_vertices();
      logic [NUM_VERTICES-1:0] links [NUM_VERTICES];
      logic [NUM_VERTICES-1:0] reached;
      logic [NUM_VERTICES-1:0] grown;
      logic [NUM_VERTICES-1:0] in_use;
      int nv;
      int ne;
      int first_row;
      int last_row;
      nv = (vertex_count > NUM_VERTICES) ? NUM_VERTICES : int'(vertex_count);
      ne = (edge_count > NUM_EDGES) ? NUM_EDGES : int'(edge_count);
      if (nv == 0) return 1'b1;
      for (int v = 0; v < NUM_VERTICES; v++) links[v] = '0;
      for (int e = 0; e < ne; e++) begin
         first_row = -1;
         last_row  = -1;
         for (int v = 0; v < nv; v++) begin
            if (incidence[v][e]) begin
               if (first_row < 0) first_row = v;
               else last_row = v;
            end
         end
         // a lone one is a self-loop; extra ones between first and last add nothing
         if (last_row >= 0) begin
            links[first_row][last_row] = 1'b1;
            links[last_row][first_row] = 1'b1;
         end
      end
      grown = 'd1;
      do begin
         reached = grown;
         for (int v = 0; v < nv; v++) begin
            if (reached[v]) grown = grown | links[v];
         end
      end while (grown != reached);
      in_use = NUM_VERTICES'((64'd1 << nv) - 64'd1);
      return (reached & in_use) == in_use;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_incidence();
         vertex_count   = 'd1;
         edge_count     = '0;
         mismatch_count = 0;
         connected_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (connected_due.size() == 0) begin
               $error("connected: expected none, actual %0b", rsp_connected);
               mismatch_count++;
            end else begin
               wanted = connected_due.pop_front();
               if (rsp_connected !== wanted) begin
                  $error("connected: expected %0b, actual %0b", wanted, rsp_connected);
                  mismatch_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == gcc_pkg::CSR_VERTEX_COUNT)
               vertex_count = csr_data[gcc_pkg::VERTEX_COUNT_WIDTH-1:0];
            else
               edge_count = csr_data[gcc_pkg::EDGE_COUNT_WIDTH-1:0];
         end
         if (req_valid && !req_stall) begin
            incidence[req_vertex_index][req_edge_index] = req_incident;
            if (req_last_cell) begin
               connected_due.push_back(reach_all_vertices());
               clear_incidence();
            end
         end
      end
      answers_due = connected_due.size();
   end

endmodule

// ===== tb/graph_connectivity_check_test.sv =====
`timescale 1ns / 1ps
// Top of the connectivity checker testbench: clock, reset, cell and size stimulus, verdict.
module graph_connectivity_check_test;
   import gcc_pkg::*;

   localparam int RANDOM_CELLS = 1150;
   localparam int CLEAR_CYCLES = 2200;   // clearing pass after an answer, with margin
   localparam int HOLD_CYCLES  = 12000;  // outlasts the longest link build and walk
   localparam int CYCLE_LIMIT  = 50_000_000;

   typedef struct packed {
      logic [VERTEX_INDEX_WIDTH-1:0] vertex;
      logic [EDGE_INDEX_WIDTH-1:0]   column;
      logic                          incident;
      logic                          last_cell;
   } cell_beat_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [VERTEX_INDEX_WIDTH-1:0] req_vertex_index;
   logic [EDGE_INDEX_WIDTH-1:0]   req_edge_index;
   logic                          req_incident;
   logic                          req_last_cell;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic                          rsp_connected;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]    csr_index;
   logic [CSR_DATA_WIDTH-1:0]     csr_data;

   int                            mismatch_count;
   int                            answers_due;
   int                            send_idle_pct = 0;
   int                            recv_idle_pct = 0;
   bit                            hold_request = 1'b0;
   int                            cells_sent = 0;
   int                            cycle_count = 0;
   logic [VERTEX_COUNT_WIDTH-1:0] cfg_vertices;
   logic [EDGE_COUNT_WIDTH-1:0]   cfg_edges;
   cell_beat_type                 cells [$];

   graph_connectivity_check u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_vertex_index (req_vertex_index),
      .req_edge_index   (req_edge_index),
      .req_incident     (req_incident),
      .req_last_cell    (req_last_cell),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_connected    (rsp_connected),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   connectivity_monitor u_monitor (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_vertex_index (req_vertex_index),
      .req_edge_index   (req_edge_index),
      .req_incident     (req_incident),
      .req_last_cell    (req_last_cell),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_connected    (rsp_connected),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatch_count   (mismatch_count),
      .answers_due      (answers_due)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // result side: random stall, plus one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic cell_beat_type make_cell(input int vertex, input int column,
                                               input bit incident, input bit last_cell);
      cell_beat_type beat;
      beat.vertex    = VERTEX_INDEX_WIDTH'(vertex);
      beat.column    = EDGE_INDEX_WIDTH'(column);
      beat.incident  = incident;
      beat.last_cell = last_cell;
      return beat;
   endfunction

   // entered and left at a falling edge; valid stays up after the beat
   task automatic send_beat(input cell_beat_type beat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_vertex_index <= beat.vertex;
      req_edge_index   <= beat.column;
      req_incident     <= beat.incident;
      req_last_cell    <= beat.last_cell;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      cells_sent++;
   endtask

   task automatic send_all();
      while (cells.size() != 0) send_beat(cells.pop_front());
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (answers_due != 0) @(negedge clock);
      repeat (CLEAR_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_graph_size(input logic [CSR_DATA_WIDTH-1:0] vertex_data,
                                 input logic [CSR_DATA_WIDTH-1:0] edge_data);
      wait_quiet();
      write_reg(CSR_VERTEX_COUNT, vertex_data);
      write_reg(CSR_EDGE_COUNT, edge_data);
      csr_valid    <= 1'b0;
      cfg_vertices = vertex_data[VERTEX_COUNT_WIDTH-1:0];
      cfg_edges    = edge_data[EDGE_COUNT_WIDTH-1:0];
   endtask

   initial begin
      int                        graph_no;
      int                        first_random;
      int                        progress;
      int                        nv;
      int                        ne;
      int                        span;
      int                        filled;
      int                        roll;
      bit                        spanning;
      logic [CSR_DATA_WIDTH-1:0] vertex_data;
      logic [CSR_DATA_WIDTH-1:0] edge_data;
      cell_beat_type             beat;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_vertex_index = '0;
      req_edge_index   = '0;
      req_incident     = 1'b0;
      req_last_cell    = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = CSR_VERTEX_COUNT;
      csr_data         = '0;
      cfg_vertices     = 'd1;
      cfg_edges        = '0;
      send_idle_pct    = 18;
      recv_idle_pct    = 45;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // reset sizes: one vertex, no edges
      cells.push_back(make_cell(0, 0, 1'b1, 1'b1));
      send_all();
      // no vertices in use: empty graph counts as connected
      set_graph_size(7'd0, 7'd64);
      cells.push_back(make_cell(31, 63, 1'b1, 1'b1));
      send_all();
      // plain link, self-loop, column with three ones, empty column, cleared cell
      set_graph_size(7'd4, 7'd4);
      cells.push_back(make_cell(0, 0, 1'b1, 1'b0));
      cells.push_back(make_cell(1, 0, 1'b1, 1'b0));
      cells.push_back(make_cell(2, 1, 1'b1, 1'b0));
      cells.push_back(make_cell(1, 2, 1'b1, 1'b0));
      cells.push_back(make_cell(2, 2, 1'b1, 1'b0));
      cells.push_back(make_cell(3, 2, 1'b1, 1'b0));
      cells.push_back(make_cell(3, 0, 1'b1, 1'b0));
      cells.push_back(make_cell(3, 0, 1'b0, 1'b0));
      cells.push_back(make_cell(0, 3, 1'b0, 1'b1));
      send_all();
      // both sizes above the store, top bit of the vertex write dropped
      set_graph_size(7'h7F, 7'h7F);
      cells.push_back(make_cell(0, 63, 1'b1, 1'b0));
      cells.push_back(make_cell(31, 63, 1'b1, 1'b1));
      send_all();
      // rows and columns beyond the sizes in use are ignored
      set_graph_size(7'd2, 7'd1);
      cells.push_back(make_cell(0, 0, 1'b1, 1'b0));
      cells.push_back(make_cell(5, 0, 1'b1, 1'b0));
      cells.push_back(make_cell(1, 1, 1'b1, 1'b0));
      cells.push_back(make_cell(0, 1, 1'b1, 1'b0));
      cells.push_back(make_cell(1, 5, 1'b0, 1'b1));
      cells.push_back(make_cell(0, 0, 1'b1, 1'b0));
      cells.push_back(make_cell(1, 0, 1'b1, 1'b1));
      send_all();

      first_random = cells_sent;
      graph_no     = 0;
      while (cells_sent - first_random < RANDOM_CELLS) begin
         progress = cells_sent - first_random;
         if (progress < RANDOM_CELLS / 3) begin
            send_idle_pct = 18;
            recv_idle_pct = 45;
         end else if (progress < 2 * RANDOM_CELLS / 3) begin
            send_idle_pct = 45;
            recv_idle_pct = 18;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // graph 5 goes in right behind graph 4 while its answer is held back
         if (graph_no == 4) hold_request = 1'b1;
         if (graph_no != 5) begin
            roll = $urandom_range(99);
            if (roll < 4) nv = 0;
            else if (roll < 12) nv = $urandom_range(63, 13);
            else nv = $urandom_range(12, 1);
            vertex_data = {($urandom_range(9) == 0), 6'(nv)};
            span = (nv > 32) ? 32 : nv;
            roll = $urandom_range(99);
            if (roll < 10) edge_data = 7'($urandom_range(127, 65));
            else if (roll < 25) edge_data = 7'($urandom_range(64));
            else edge_data = 7'(((span == 0) ? 0 : span - 1) + $urandom_range(3));
            set_graph_size(vertex_data, edge_data);
         end

         nv       = (cfg_vertices > 32) ? 32 : int'(cfg_vertices);
         ne       = (cfg_edges > 64) ? 64 : int'(cfg_edges);
         span     = (nv == 0) ? 32 : nv;
         filled   = (ne < nv + 3) ? ne : nv + 3;
         spanning = ($urandom_range(99) < 60);
         for (int e = 0; e < filled; e++) begin
            roll = $urandom_range(99);
            if (spanning && e + 1 < span && roll < 95) begin
               // tree edge: hooks vertex e+1 onto an earlier one
               cells.insert($urandom_range(cells.size()), make_cell(e + 1, e, 1'b1, 1'b0));
               cells.insert($urandom_range(cells.size()),
                            make_cell($urandom_range(e), e, 1'b1, 1'b0));
            end else if (roll < 60) begin
               repeat (2)
                  cells.insert($urandom_range(cells.size()),
                               make_cell($urandom_range(span - 1), e, 1'b1, 1'b0));
            end else if (roll < 75) begin
               cells.insert($urandom_range(cells.size()),
                            make_cell($urandom_range(span - 1), e, 1'b1, 1'b0));
            end else if (roll < 90) begin
               repeat (3)
                  cells.insert($urandom_range(cells.size()),
                               make_cell($urandom_range(span - 1), e, 1'b1, 1'b0));
            end
         end
         repeat ($urandom_range(3))
            cells.insert($urandom_range(cells.size()),
                         make_cell($urandom_range(31), $urandom_range(63),
                                   $urandom_range(1), 1'b0));
         if (cells.size() != 0 && $urandom_range(99) < 15) begin
            beat          = cells[$urandom_range(cells.size() - 1)];
            beat.incident = 1'b0;
            cells.push_back(beat);
         end
         if (cells.size() != 0 && $urandom_range(1) == 1)
            cells[cells.size() - 1].last_cell = 1'b1;
         else
            cells.push_back(make_cell($urandom_range(31), $urandom_range(63),
                                      $urandom_range(1), 1'b1));
         send_all();
         graph_no++;
      end

      wait_quiet();
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
